[rtl/median3_ema_sensor_filter_core_defines.svh]
// ----------------------------------------------------------------------------
// Median3 EMA sensor filter: assertion macros
// Shared concurrent assertion forms used by the queue and back-end modules.
// ----------------------------------------------------------------------------
`ifndef MEDIAN3_EMA_SENSOR_FILTER_CORE_DEFINES_SVH
`define MEDIAN3_EMA_SENSOR_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define M3EMA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m3ema: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define M3EMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m3ema: next-cycle check failed");

`endif

[rtl/m3ema_pkg.sv]
// ----------------------------------------------------------------------------
// Median3 EMA sensor filter package
// Field widths, register indexes, shared structs and fixed constants.
// ----------------------------------------------------------------------------
package m3ema_pkg;

   // Field widths.
   localparam int TEMP_W     = 15;
   localparam int HUM_W      = 14;
   localparam int OUT_T_W    = 16;
   localparam int OUT_H_W    = 15;
   localparam int OFF_W      = 11;
   localparam int WEIGHT_W   = 9;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_ADDR_W = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FAHRENHEIT_MODE,
      CSR_TEMP_TRIM,
      CSR_HUM_TRIM,
      CSR_EMA_WEIGHT
   } csr_index_type;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd51;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 9'd256;
   localparam int                  WEIGHT_SHIFT = 8;

   // Fahrenheit conversion: floor((18t + 5) / 10) + 3200, done as
   // floor((18t + 5 + BIAS) / 10) - (BIAS / 10 - 3200) with a reciprocal.
   localparam int DIV10_MUL   = 838861;
   localparam int DIV10_SHIFT = 23;
   localparam int DIV10_BIAS  = 300000;
   localparam int FAHR_SUB    = 26800;
   localparam int QUOT_W      = 16;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Median pair handed from front to back.
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic        [HUM_W-1:0]  hum;
   } med_type;

   // Configuration register set.
   typedef struct packed {
      logic                     fahrenheit;
      logic signed [OFF_W-1:0]  temp_trim;
      logic signed [OFF_W-1:0]  hum_trim;
      logic        [WEIGHT_W-1:0] weight;
   } cfg_type;

endpackage

[rtl/m3ema_front.sv]
// ----------------------------------------------------------------------------
// Median3 EMA filter front end
// Accepts requests, drops failed readings, fills the sample windows and
// forms the median pair of each full window.
// ----------------------------------------------------------------------------
module m3ema_front #(
   parameter int WINDOW_SIZE = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [m3ema_pkg::TEMP_W-1:0] in_temp,
   input  logic        [m3ema_pkg::HUM_W-1:0]  in_hum,
   input  logic                          in_ok,
   output logic                          push,
   output m3ema_pkg::med_type            push_data,
   input  logic                          q_full
);
   import m3ema_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_SIZE);
   localparam int MID   = WINDOW_SIZE / 2;

   logic signed [TEMP_W-1:0] t_win_ff [WINDOW_SIZE];
   logic        [HUM_W-1:0]  h_win_ff [WINDOW_SIZE];
   logic [CNT_W-1:0]         fill_ff;
   logic                     pend_ff;
   logic                     take;
   logic [CNT_W-1:0]         t_rank [WINDOW_SIZE];
   logic [CNT_W-1:0]         h_rank [WINDOW_SIZE];

   // A full window blocks new requests until its median is queued.
   assign in_ready = !pend_ff;
   assign take     = in_valid && in_ready && in_ok;
   assign push     = pend_ff && !q_full;

   // Fill count and pending-median flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (take) begin
            if (fill_ff == CNT_W'(WINDOW_SIZE - 1)) begin
               fill_ff <= '0;
               pend_ff <= 1'b1;
            end else begin
               fill_ff <= fill_ff + 1'b1;
            end
         end else if (push) begin
            pend_ff <= 1'b0;
         end
      end
   end

   // Sample windows.
   always_ff @(posedge clock) begin
      if (take) begin
         t_win_ff[fill_ff] <= in_temp;
         h_win_ff[fill_ff] <= in_hum;
      end
   end

   // Rank each entry (ties broken by position); the middle rank is the median.
   always_comb begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         t_rank[i] = '0;
         h_rank[i] = '0;
         for (int j = 0; j < WINDOW_SIZE; j++) begin
            if (j != i) begin
               if (t_win_ff[j] < t_win_ff[i] || (t_win_ff[j] == t_win_ff[i] && j < i)) begin
                  t_rank[i] = t_rank[i] + 1'b1;
               end
               if (h_win_ff[j] < h_win_ff[i] || (h_win_ff[j] == h_win_ff[i] && j < i)) begin
                  h_rank[i] = h_rank[i] + 1'b1;
               end
            end
         end
      end
      push_data.temp = t_win_ff[0];
      push_data.hum  = h_win_ff[0];
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         if (t_rank[i] == CNT_W'(MID)) begin
            push_data.temp = t_win_ff[i];
         end
         if (h_rank[i] == CNT_W'(MID)) begin
            push_data.hum = h_win_ff[i];
         end
      end
   end

endmodule

[rtl/m3ema_queue.sv]
// ----------------------------------------------------------------------------
// Median3 EMA filter queue
// Short first-in first-out buffer of median pairs between front and back.
// ----------------------------------------------------------------------------
`include "median3_ema_sensor_filter_core_defines.svh"

module m3ema_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  m3ema_pkg::med_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output m3ema_pkg::med_type pop_data
);
   import m3ema_pkg::*;

   med_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `M3EMA_ASSERT_IMPLIES(a_q_no_overflow, clock, reset, push, count_ff != QCNT_W'(QUEUE_DEPTH))
   `M3EMA_ASSERT_IMPLIES(a_q_no_underflow, clock, reset, pop, count_ff != '0)

endmodule

[rtl/m3ema_back.sv]
// ----------------------------------------------------------------------------
// Median3 EMA filter back end
// Converts and calibrates each median pair, updates both moving averages
// on one shared multiplier and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "median3_ema_sensor_filter_core_defines.svh"

module m3ema_back #(
   parameter int AVG_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  m3ema_pkg::cfg_type            cfg,
   input  logic                          q_valid,
   input  m3ema_pkg::med_type            q_data,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [m3ema_pkg::OUT_T_W-1:0] out_temp,
   output logic signed [m3ema_pkg::OUT_H_W-1:0] out_hum
);
   import m3ema_pkg::*;

   localparam int AVG_W   = OUT_T_W + AVG_FRAC_BITS;
   localparam int MUL_A_W = AVG_W + 1;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int RND_W   = AVG_W + 1;
   localparam int SHR_W   = RND_W - AVG_FRAC_BITS;
   localparam int CAL_W   = OUT_T_W + 2;
   localparam int HCAL_W  = OUT_H_W + 1;

   localparam logic signed [MUL_A_W-1:0] K18       = MUL_A_W'(18);
   localparam logic signed [MUL_A_W-1:0] KBIAS     = MUL_A_W'(DIV10_BIAS + 5);
   localparam logic signed [MUL_B_W-1:0] KDIV      = MUL_B_W'(DIV10_MUL);
   localparam logic signed [CAL_W-1:0]   KFSUB     = CAL_W'(FAHR_SUB);
   localparam logic signed [CAL_W-1:0]   T_MAX     = CAL_W'(32767);
   localparam logic signed [CAL_W-1:0]   T_MIN     = -CAL_W'(32768);
   localparam logic signed [HCAL_W-1:0]  H_MAX     = HCAL_W'(16383);
   localparam logic signed [HCAL_W-1:0]  H_MIN     = -HCAL_W'(16384);
   localparam logic signed [SHR_W-1:0]   OT_MAX    = SHR_W'(32767);
   localparam logic signed [SHR_W-1:0]   OT_MIN    = -SHR_W'(32768);
   localparam logic signed [SHR_W-1:0]   OH_MAX    = SHR_W'(16383);
   localparam logic signed [SHR_W-1:0]   OH_MIN    = -SHR_W'(16384);
   localparam logic signed [RND_W-1:0]   HALF      = RND_W'(1) <<< (AVG_FRAC_BITS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_CAL,
      S_MT,
      S_UT,
      S_UH,
      S_OUT
   } state_type;

   state_type                   state_ff;
   med_type                     med_ff;
   logic signed [OUT_T_W-1:0]   tcal_ff;
   logic signed [OUT_H_W-1:0]   hcal_ff;
   logic signed [AVG_W-1:0]     avg_t_ff;
   logic signed [AVG_W-1:0]     avg_h_ff;
   logic                        avg_valid_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic                        rsp_valid_ff;
   logic signed [OUT_T_W-1:0]   rsp_temp_ff;
   logic signed [OUT_H_W-1:0]   rsp_hum_ff;

   logic [WEIGHT_W-1:0]         weight;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [CAL_W-1:0]     t_conv;
   logic signed [CAL_W-1:0]     t_sum;
   logic signed [HCAL_W-1:0]    h_sum;
   logic signed [OUT_T_W-1:0]   tcal_in;
   logic signed [OUT_H_W-1:0]   hcal_in;
   logic signed [RND_W-1:0]     rnd_t;
   logic signed [RND_W-1:0]     rnd_h;
   logic signed [SHR_W-1:0]     shr_t;
   logic signed [SHR_W-1:0]     shr_h;
   logic signed [OUT_T_W-1:0]   out_t_in;
   logic signed [OUT_H_W-1:0]   out_h_in;

   assign pop       = (state_ff == S_IDLE) && q_valid;
   assign out_valid = rsp_valid_ff;
   assign out_temp  = rsp_temp_ff;
   assign out_hum   = rsp_hum_ff;

   // Weights above one are held at one.
   assign weight = (cfg.weight > WEIGHT_MAX) ? WEIGHT_MAX : cfg.weight;

   // Shared multiplier: the divide-by-ten reciprocal, then the two EMA steps.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_CONV: begin
            mul_a = MUL_A_W'(med_ff.temp) * K18 + KBIAS;
            mul_b = KDIV;
         end
         S_MT: begin
            mul_a = (MUL_A_W'(tcal_ff) <<< AVG_FRAC_BITS) - MUL_A_W'(avg_t_ff);
            mul_b = $signed(MUL_B_W'(weight));
         end
         S_UT: begin
            mul_a = (MUL_A_W'(hcal_ff) <<< AVG_FRAC_BITS) - MUL_A_W'(avg_h_ff);
            mul_b = $signed(MUL_B_W'(weight));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // Unit conversion, offset and saturation.
   always_comb begin
      t_conv = $signed({2'b00, prod_ff[DIV10_SHIFT +: QUOT_W]}) - KFSUB;
      if (!cfg.fahrenheit) begin
         t_conv = CAL_W'(med_ff.temp);
      end
      t_sum = t_conv + CAL_W'(cfg.temp_trim);
      h_sum = $signed({2'b00, med_ff.hum}) + HCAL_W'(cfg.hum_trim);
      if (t_sum > T_MAX) begin
         tcal_in = OUT_T_W'(T_MAX);
      end else if (t_sum < T_MIN) begin
         tcal_in = OUT_T_W'(T_MIN);
      end else begin
         tcal_in = OUT_T_W'(t_sum);
      end
      if (h_sum > H_MAX) begin
         hcal_in = OUT_H_W'(H_MAX);
      end else if (h_sum < H_MIN) begin
         hcal_in = OUT_H_W'(H_MIN);
      end else begin
         hcal_in = OUT_H_W'(h_sum);
      end
   end

   // Round half up out of the averages and saturate to the output fields.
   always_comb begin
      rnd_t = RND_W'(avg_t_ff) + HALF;
      rnd_h = RND_W'(avg_h_ff) + HALF;
      shr_t = SHR_W'(rnd_t >>> AVG_FRAC_BITS);
      shr_h = SHR_W'(rnd_h >>> AVG_FRAC_BITS);
      if (shr_t > OT_MAX) begin
         out_t_in = OUT_T_W'(OT_MAX);
      end else if (shr_t < OT_MIN) begin
         out_t_in = OUT_T_W'(OT_MIN);
      end else begin
         out_t_in = OUT_T_W'(shr_t);
      end
      if (shr_h > OH_MAX) begin
         out_h_in = OUT_H_W'(OH_MAX);
      end else if (shr_h < OH_MIN) begin
         out_h_in = OUT_H_W'(OH_MIN);
      end else begin
         out_h_in = OUT_H_W'(shr_h);
      end
   end

   // Sequencer, averages and output register.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         avg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The output register fills in S_OUT once its previous pair has left.
         if (state_ff == S_OUT && (!rsp_valid_ff || out_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  med_ff   <= q_data;
                  state_ff <= S_CONV;
               end
            end
            S_CONV: begin
               state_ff <= S_CAL;
            end
            S_CAL: begin
               tcal_ff <= tcal_in;
               hcal_ff <= hcal_in;
               if (avg_valid_ff) begin
                  state_ff <= S_MT;
               end else begin
                  avg_t_ff     <= AVG_W'(tcal_in) <<< AVG_FRAC_BITS;
                  avg_h_ff     <= AVG_W'(hcal_in) <<< AVG_FRAC_BITS;
                  avg_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end
            end
            S_MT: begin
               state_ff <= S_UT;
            end
            S_UT: begin
               avg_t_ff <= avg_t_ff + AVG_W'(prod_ff >>> WEIGHT_SHIFT);
               state_ff <= S_UH;
            end
            S_UH: begin
               avg_h_ff <= avg_h_ff + AVG_W'(prod_ff >>> WEIGHT_SHIFT);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || out_ready) begin
                  rsp_temp_ff <= out_t_in;
                  rsp_hum_ff  <= out_h_in;
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `M3EMA_ASSERT_NEXT(a_idle_waits, clock, reset, state_ff == S_IDLE && !q_valid, state_ff == S_IDLE)
   `M3EMA_ASSERT_NEXT(a_avg_sticky, clock, reset, avg_valid_ff, avg_valid_ff)
   `M3EMA_ASSERT_IMPLIES(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_OUT))

endmodule

[rtl/median3_ema_sensor_filter_core.sv]
// ----------------------------------------------------------------------------
// Median3 EMA sensor filter core
// Median-of-window then exponential moving average of temperature/humidity.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the req_ stream: temperature and humidity in hundredths,
// with req_tuser set when the reading is good. Failed readings are taken and
// dropped. Every WINDOW_SIZE good readings give one filtered pair on the
// rsp_ stream; nothing else comes out.
// The front takes one request per cycle; after the last good reading of a
// window it holds req_tready low while the median is queued.
// The back works one median pair at a time through S_IDLE, S_CONV, S_CAL
// and S_OUT for the first pair after reset, adding S_MT, S_UT and S_UH for
// later pairs, as the single shared multiplier serves the Fahrenheit divide
// and both average updates. A two-entry queue lets the front keep filling
// windows while the back or a stalled receiver holds a result; when a window
// completes with the queue full, req_tready stays low until its median is
// queued.
// Reset clears the windows' fill count, the average (the first pair after
// reset seeds it) and the registers to their defaults (weight 51).
// Register writes on csr_ apply to the next pair; make them while idle.
// ----------------------------------------------------------------------------
module median3_ema_sensor_filter_core #(
   parameter int WINDOW_SIZE   = 3,
   parameter int AVG_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request stream.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [31:0]                           req_tdata,  // temp_sample[14:0], hum_sample[28:15]
   input  logic                                  req_tuser,  // reading_ok[0]
   // Response stream.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [31:0]                           rsp_tdata,  // filtered_temp[15:0], filtered_hum[30:16]
   // Configuration write port.
   input  logic                                  csr_we,
   input  logic [m3ema_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [m3ema_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import m3ema_pkg::*;

   cfg_type                   cfg_ff;
   logic                      push;
   med_type                   push_data;
   logic                      q_full;
   logic                      q_valid;
   logic                      pop;
   med_type                   pop_data;
   logic signed [OUT_T_W-1:0] out_temp;
   logic signed [OUT_H_W-1:0] out_hum;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fahrenheit <= 1'b0;
         cfg_ff.temp_trim  <= '0;
         cfg_ff.hum_trim   <= '0;
         cfg_ff.weight     <= WEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_FAHRENHEIT_MODE: cfg_ff.fahrenheit <= csr_wdata[0];
            CSR_TEMP_TRIM:       cfg_ff.temp_trim  <= $signed(csr_wdata[OFF_W-1:0]);
            CSR_HUM_TRIM:        cfg_ff.hum_trim   <= $signed(csr_wdata[OFF_W-1:0]);
            CSR_EMA_WEIGHT:      cfg_ff.weight     <= csr_wdata[WEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   m3ema_front #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_temp   ($signed(req_tdata[TEMP_W-1:0])),
      .in_hum    (req_tdata[TEMP_W +: HUM_W]),
      .in_ok     (req_tuser),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   m3ema_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   m3ema_back #(
      .AVG_FRAC_BITS (AVG_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (pop_data),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_temp  (out_temp),
      .out_hum   (out_hum)
   );

   // Pack the response fields, padded to whole bytes.
   assign rsp_tdata = {1'b0, out_hum, out_temp};

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median3 EMA sensor filter core regression bench
// Sends temperature/humidity requests, some flagged as failed, through the
// filter under several register settings, predicts each filtered pair with
// an in-bench median/average model, and checks every response in order.
// Both stream sides idle at random; one test holds off the receiver to back
// the filter up, another lets every result drain between short bursts.
// ----------------------------------------------------------------------------
module tb;
   import m3ema_pkg::*;

   localparam int     WINDOW_LEN    = 3;
   localparam int     AVG_FRAC      = 8;
   localparam longint AVG_ONE       = longint'(1) << AVG_FRAC;
   localparam longint AVG_HALF      = AVG_ONE / 2;
   localparam longint OUT_T_MAX     = (longint'(1) << (OUT_T_W - 1)) - 1;
   localparam longint OUT_T_MIN     = -OUT_T_MAX - 1;
   localparam longint OUT_H_MAX     = (longint'(1) << (OUT_H_W - 1)) - 1;
   localparam longint OUT_H_MIN     = -OUT_H_MAX - 1;
   localparam int     FAHR_BASE     = 3200;
   localparam int     SETTLE_CYCLES = 24;
   localparam int     CYCLE_LIMIT   = 400000;
   localparam int     RANDOM_PHASES = 8;
   localparam int     PHASE_ITEMS   = 145;
   localparam int     PRINT_CAP     = 50;

   typedef struct {
      logic signed [OUT_T_W-1:0] temp;
      logic signed [OUT_H_W-1:0] hum;
   } filtered_pair_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;   // temp_sample[14:0], hum_sample[28:15]
   logic                  req_tuser;   // reading_ok[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;   // filtered_temp[15:0], filtered_hum[30:16]
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predicted filter state and register copies.
   longint                     win_temp [WINDOW_LEN];
   longint                     win_hum  [WINDOW_LEN];
   int                         win_fill;
   longint                     avg_temp;
   longint                     avg_hum;
   bit                         avg_seeded;
   logic                       cfg_fahrenheit;
   logic signed [OFF_W-1:0]    cfg_temp_trim;
   logic signed [OFF_W-1:0]    cfg_hum_trim;
   logic [WEIGHT_W-1:0]        cfg_weight;

   filtered_pair_type          filtered_pending[$];

   // Run control and statistics.
   bit                         send_idle_on;
   bit                         rsp_stall_on;
   int                         hold_off_cycles;
   int                         cycle_count;
   int                         error_count;
   int                         results_checked;
   int                         readings_sent;
   int                         good_sent;
   int                         settings_count;
   logic signed [TEMP_W-1:0]   last_temp;
   logic [HUM_W-1:0]           last_hum;

   median3_ema_sensor_filter_core #(
      .WINDOW_SIZE  (WINDOW_LEN),
      .AVG_FRAC_BITS(AVG_FRAC)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock, 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                  filtered_pending.size());
         $display("median3_ema_sensor_filter_core regression: fail");
         $finish;
      end
   end

   function automatic int draw_gap(input bit enabled);
      if (!enabled || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint mid_of_three(input longint a, input longint b, input longint c);
      longint lo;
      longint hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      // The median is the larger of the low one and min(high one, c).
      return (lo > ((hi < c) ? hi : c)) ? lo : ((hi < c) ? hi : c);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   // Predict the effect of one accepted request on the filter.
   task automatic filter_reading(input logic signed [TEMP_W-1:0] t_in,
                                 input logic [HUM_W-1:0] h_in, input logic ok);
      longint            t;
      longint            h;
      longint            w;
      longint            x;
      filtered_pair_type pair;
      if (!ok) return;
      if (win_fill >= WINDOW_LEN) win_fill = 0;
      win_temp[win_fill] = longint'(t_in);
      win_hum[win_fill]  = longint'(h_in);
      win_fill++;
      if (win_fill < WINDOW_LEN) return;
      win_fill = 0;

      t = mid_of_three(win_temp[0], win_temp[1], win_temp[2]);
      h = mid_of_three(win_hum[0], win_hum[1], win_hum[2]);
      // Fahrenheit is 9t/5 + 3200 rounded to nearest, using a floor division by ten.
      if (cfg_fahrenheit) begin
         x = 18 * t + 5;
         t = ((x >= 0) ? x / 10 : -((9 - x) / 10)) + FAHR_BASE;
      end
      t = clamp(t + longint'(cfg_temp_trim), OUT_T_MIN, OUT_T_MAX);
      h = clamp(h + longint'(cfg_hum_trim), OUT_H_MIN, OUT_H_MAX);

      // The first pair after reset seeds the average; later pairs move it.
      w = longint'((cfg_weight > WEIGHT_MAX) ? WEIGHT_MAX : cfg_weight);
      if (!avg_seeded) begin
         avg_temp   = t * AVG_ONE;
         avg_hum    = h * AVG_ONE;
         avg_seeded = 1'b1;
      end else begin
         avg_temp = avg_temp + ((w * (t * AVG_ONE - avg_temp)) >>> WEIGHT_SHIFT);
         avg_hum  = avg_hum + ((w * (h * AVG_ONE - avg_hum)) >>> WEIGHT_SHIFT);
      end

      pair.temp = OUT_T_W'(clamp((avg_temp + AVG_HALF) >>> AVG_FRAC, OUT_T_MIN, OUT_T_MAX));
      pair.hum  = OUT_H_W'(clamp((avg_hum + AVG_HALF) >>> AVG_FRAC, OUT_H_MIN, OUT_H_MAX));
      filtered_pending.push_back(pair);
   endtask

   // Offer one request after a random gap and wait until it is taken.
   task automatic send_reading(input logic signed [TEMP_W-1:0] t_in,
                               input logic [HUM_W-1:0] h_in, input logic ok);
      int gap;
      gap = draw_gap(send_idle_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, h_in, t_in};
      req_tuser  <= ok;
      do @(posedge clock); while (!req_tready);
      readings_sent++;
      if (ok) good_sent++;
      last_temp = t_in;
      last_hum  = h_in;
      filter_reading(t_in, h_in, ok);
   endtask

   // Stop sending and wait until every predicted result has been checked.
   task automatic wait_results(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (filtered_pending.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all four registers on consecutive cycles; the filter must be idle.
   task automatic apply_settings(input logic fahr, input logic signed [OFF_W-1:0] toff,
                                 input logic signed [OFF_W-1:0] hoff,
                                 input logic [WEIGHT_W-1:0] weight);
      write_csr(CSR_FAHRENHEIT_MODE, CSR_DATA_W'(fahr));
      write_csr(CSR_TEMP_TRIM, toff);
      write_csr(CSR_HUM_TRIM, hoff);
      write_csr(CSR_EMA_WEIGHT, CSR_DATA_W'(weight));
      csr_we         <= 1'b0;
      cfg_fahrenheit = fahr;
      cfg_temp_trim  = toff;
      cfg_hum_trim   = hoff;
      cfg_weight     = weight;
      settings_count++;
   endtask

   // Mostly plausible readings, some with arbitrary bits, some repeats for ties.
   task automatic send_random_reading();
      logic signed [TEMP_W-1:0] t;
      logic [HUM_W-1:0]         h;
      logic                     ok;
      int                       pick;
      ok   = ($urandom_range(0, 7) != 0);
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
         t = TEMP_W'($urandom_range(0, 16500) - 4000);
         h = HUM_W'($urandom_range(0, 10000));
      end else if (pick <= 8) begin
         t = TEMP_W'($urandom());
         h = HUM_W'($urandom());
      end else begin
         t = last_temp;
         h = last_hum;
      end
      send_reading(t, h, ok);
   endtask

   // Response side: ready is dropped for random stalls or a requested hold-off.
   initial begin : rsp_side
      int wait_left;
      wait_left = 0;
      forever begin
         if (hold_off_cycles > 0) begin
            wait_left       = hold_off_cycles;
            hold_off_cycles = 0;
         end
         rsp_tready <= (wait_left == 0);
         @(posedge clock);
         if (wait_left > 0)
            wait_left--;
         else if (rsp_tvalid)
            wait_left = draw_gap(rsp_stall_on);
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      filtered_pair_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_pending.size() == 0) begin
            report_mismatch($sformatf("response %h with nothing expected", rsp_tdata));
         end else begin
            want = filtered_pending.pop_front();
            results_checked++;
            if (rsp_tdata[OUT_T_W-1:0] !== want.temp)
               report_mismatch($sformatf("filtered_temp %0d, expected %0d",
                                         $signed(rsp_tdata[OUT_T_W-1:0]), want.temp));
            if (rsp_tdata[16 +: OUT_H_W] !== want.hum)
               report_mismatch($sformatf("filtered_hum %0d, expected %0d",
                                         $signed(rsp_tdata[16 +: OUT_H_W]), want.hum));
         end
      end
   end

   // Reset defaults, field extremes, failed readings, saturation and odd weights.
   task automatic test_directed();
      send_reading(16383, 16383, 1'b0);
      send_reading(-16384, 0, 1'b1);
      send_reading(16383, 16383, 1'b1);
      send_reading(0, 5000, 1'b1);
      send_reading(12500, 10000, 1'b1);
      send_reading(-16384, 16383, 1'b0);
      send_reading(-4000, 0, 1'b1);
      send_reading(2500, 4500, 1'b1);
      repeat (WINDOW_LEN) send_reading(777, 777, 1'b1);

      // Largest offsets in Fahrenheit push both channels into saturation.
      wait_results(SETTLE_CYCLES);
      apply_settings(1'b1, 11'sd1023, 11'sd1023, WEIGHT_MAX);
      repeat (WINDOW_LEN) send_reading(16383, 16383, 1'b1);

      // Weight zero freezes the average.
      wait_results(SETTLE_CYCLES);
      apply_settings(1'b1, -11'sd1024, -11'sd1024, 9'd0);
      repeat (WINDOW_LEN) send_reading(-16384, 0, 1'b1);

      // Weight above full scale acts as no smoothing.
      wait_results(SETTLE_CYCLES);
      apply_settings(1'b0, 11'sd0, 11'sd0, 9'd511);
      send_reading(-4000, 0, 1'b1);
      send_reading(12500, 10000, 1'b1);
      send_reading(100, 200, 1'b1);
   endtask

   // Hold the receiver off while requests keep coming, so the filter backs up.
   task automatic test_backpressure();
      wait_results(SETTLE_CYCLES);
      send_idle_on    = 1'b0;
      rsp_stall_on    = 1'b0;
      hold_off_cycles = 400;
      repeat (15 * WINDOW_LEN) send_random_reading();
      send_idle_on = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   // Short bursts, each followed by a pause until all results are back.
   task automatic test_drain_between_bursts();
      repeat (12) begin
         repeat ($urandom_range(1, 6)) send_random_reading();
         wait_results(0);
      end
   endtask

   // Long random runs under a series of register settings.
   task automatic test_random_settings();
      logic                    fahr;
      logic signed [OFF_W-1:0] toff;
      logic signed [OFF_W-1:0] hoff;
      logic [WEIGHT_W-1:0]     weight;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               fahr = 1'b0; toff = 11'sd0; hoff = 11'sd0; weight = 9'd26;
            end
            1: begin
               fahr = 1'b1; toff = 11'sd1023; hoff = 11'sd1023; weight = WEIGHT_MAX;
            end
            2: begin
               fahr = 1'b0; toff = -11'sd1024; hoff = -11'sd1024; weight = 9'd1;
            end
            default: begin
               fahr   = 1'($urandom());
               toff   = OFF_W'($urandom_range(0, 2047));
               hoff   = OFF_W'($urandom_range(0, 2047));
               weight = ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom_range(0, 511))
                                                     : WEIGHT_W'($urandom_range(26, 256));
            end
         endcase
         wait_results(SETTLE_CYCLES);
         apply_settings(fahr, toff, hoff, weight);
         // Every third phase runs both sides flat out.
         send_idle_on = (phase % 3 != 0);
         rsp_stall_on = (phase % 3 != 0);
         repeat (PHASE_ITEMS) send_random_reading();
      end
   endtask

   // Main sequence.
   initial begin
      reset           <= 1'b1;
      req_tvalid      <= 1'b0;
      req_tdata       <= '0;
      req_tuser       <= 1'b0;
      csr_we          <= 1'b0;
      csr_addr        <= CSR_FAHRENHEIT_MODE;
      csr_wdata       <= '0;
      win_fill        = 0;
      avg_temp        = 0;
      avg_hum         = 0;
      avg_seeded      = 1'b0;
      cfg_fahrenheit  = 1'b0;
      cfg_temp_trim   = '0;
      cfg_hum_trim    = '0;
      cfg_weight      = WEIGHT_RESET;
      send_idle_on    = 1'b1;
      rsp_stall_on    = 1'b1;
      hold_off_cycles = 0;
      cycle_count     = 0;
      error_count     = 0;
      results_checked = 0;
      readings_sent   = 0;
      good_sent       = 0;
      settings_count  = 0;
      last_temp       = '0;
      last_hum        = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_drain_between_bursts();
      test_random_settings();
      wait_results(SETTLE_CYCLES);

      $display("Covered %0d requests (%0d good readings) under %0d register settings,",
               readings_sent, good_sent, settings_count);
      $display("with receiver hold-off, drained bursts and %0d checked filtered pairs.",
               results_checked);
      if (error_count == 0)
         $display("median3_ema_sensor_filter_core regression: pass");
      else
         $display("median3_ema_sensor_filter_core regression: fail");
      $finish;
   end

endmodule
